FILE: hdl/pqm_pkg.sv
// Shared types and constants for the pixel quality mask block.
// No dependencies; every other file in this block imports it.
package pqm_pkg;

   // Widths of the radiance samples and of the gain registers.
   localparam int RAD_BITS  = 16;
   localparam int GAIN_BITS = 32;

   // Configuration port shape and register indexes.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_BLUE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_RED    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_NIR    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_SWIR   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWIR_ENABLE = 3'd4;

   // Bit positions inside the quality mask.
   localparam int Q_CLOUD_BIT  = 0;
   localparam int Q_SHADOW_BIT = 1;
   localparam int Q_WATER_BIT  = 2;
   localparam int Q_SNOW_BIT   = 3;
   localparam int Q_BITS       = 4;

   // One input item.
   typedef struct packed {
      logic [RAD_BITS-1:0] blue_radiance;
      logic [RAD_BITS-1:0] red_radiance;
      logic [RAD_BITS-1:0] nir_radiance;
      logic [RAD_BITS-1:0] swir_radiance;
      logic                last_pixel;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [Q_BITS-1:0] quality_bits;
      logic              scene_end;
   } rsp_type;

   // Per-item control that travels beside the reflectance data.
   typedef struct packed {
      logic pix_ok;
      logic snow_on;
      logic last;
   } ctrl_type;

   // Threshold and ratio test results of one pixel.
   typedef struct packed {
      logic rb_gt25;
      logic rn_gt60;
      logic ndvi_lt02;
      logic ndvi_lt0;
      logic rb_lt4;
      logic rr_lt4;
      logic rn_lt4;
      logic rn_lt5;
      logic rn_gt10;
      logic ndsi_gt04;
   } flags_type;

endpackage

FILE: hdl/pqm_refl.sv
// One band's radiance to reflectance conversion: multiply, then shift and saturate.
// Depends on pqm_pkg for the radiance and gain widths.
module pqm_refl #(
   parameter int REFL_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic [pqm_pkg::RAD_BITS-1:0]   rad,
   input  logic [pqm_pkg::GAIN_BITS-1:0]  gain,
   output logic [REFL_FRAC_BITS+3:0]      refl
);
   import pqm_pkg::*;

   localparam int PROD_BITS  = RAD_BITS + GAIN_BITS;
   localparam int REFL_BITS  = REFL_FRAC_BITS + 4;
   localparam int REFL_SHIFT = REFL_FRAC_BITS + 8;
   localparam logic [PROD_BITS-1:0] REFL_MAX = PROD_BITS'((64'd1 << REFL_BITS) - 64'd1);

   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [PROD_BITS-1:0] shifted;
   logic [REFL_BITS-1:0] refl_ff, refl_in;

   function automatic logic [PROD_BITS-1:0] prod_in_shift(input logic [PROD_BITS-1:0] p);
      prod_in_shift = p >> REFL_SHIFT;
   endfunction

   // First stage: the full product of radiance and gain.
   assign prod_in = PROD_BITS'(rad) * PROD_BITS'(gain);

   // Second stage: drop the fraction bits and clamp to the reflectance range.
   assign shifted = prod_in_shift(prod_ff);
   assign refl_in = (shifted > REFL_MAX) ? REFL_MAX[REFL_BITS-1:0] : shifted[REFL_BITS-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      refl_ff <= refl_in;
   end

   assign refl = refl_ff;

endmodule

FILE: hdl/pixel_quality_mask_top.sv
// Top level of the pixel quality mask: configuration registers and the mask pipeline.
// Depends on pqm_pkg and pqm_refl.
// An accepted item passes the product, reflectance, compare and mask registers in turn
// and is then shown on rsp_data with rsp_valid high.
// Throughput: one item per clock; busy stays low, as every stage advances each cycle.
// Stages: product, reflectance clamp, threshold compares, mask register.
// Reset clears the pipeline valid bits and all configuration registers to zero.
module pixel_quality_mask_top #(
   parameter int REFL_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  pqm_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   output pqm_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_en,
   input  logic [pqm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pqm_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import pqm_pkg::*;

   localparam int REFL_BITS = REFL_FRAC_BITS + 4;
   localparam int CMP_BITS  = REFL_BITS + 3;

   // Percent thresholds in reflectance units, rounded half up.
   localparam logic [REFL_BITS-1:0] T4  = REFL_BITS'(((64'd4  << REFL_FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [REFL_BITS-1:0] T5  = REFL_BITS'(((64'd5  << REFL_FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [REFL_BITS-1:0] T10 = REFL_BITS'(((64'd10 << REFL_FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [REFL_BITS-1:0] T25 = REFL_BITS'(((64'd25 << REFL_FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [REFL_BITS-1:0] T60 = REFL_BITS'(((64'd60 << REFL_FRAC_BITS) + 64'd50) / 64'd100);

   // Configuration registers.
   logic [GAIN_BITS-1:0] gain_blue_ff, gain_red_ff, gain_nir_ff, gain_swir_ff;
   logic                 swir_enable_ff;

   // Pipeline valid bits and side data.
   logic      accept;
   logic      valid1_ff, valid2_ff, valid3_ff, rsp_valid_ff;
   ctrl_type  ctrl1_in, ctrl1_ff, ctrl2_ff, ctrl3_ff;
   flags_type flags3_in, flags3_ff;
   rsp_type   rsp_in, rsp_ff;

   // Reflectances out of the band converters.
   logic [REFL_BITS-1:0] rb, rr, rn, rs;
   logic [CMP_BITS-1:0]  rn_x2, rr_x3, rb_x3, rs_x7;

   assign accept = start && !busy;
   assign busy   = 1'b0;

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_blue_ff   <= '0;
         gain_red_ff    <= '0;
         gain_nir_ff    <= '0;
         gain_swir_ff   <= '0;
         swir_enable_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GAIN_BLUE:   gain_blue_ff   <= csr_data[GAIN_BITS-1:0];
            CSR_GAIN_RED:    gain_red_ff    <= csr_data[GAIN_BITS-1:0];
            CSR_GAIN_NIR:    gain_nir_ff    <= csr_data[GAIN_BITS-1:0];
            CSR_GAIN_SWIR:   gain_swir_ff   <= csr_data[GAIN_BITS-1:0];
            CSR_SWIR_ENABLE: swir_enable_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Band converters cover the first two stages.
   pqm_refl #(.REFL_FRAC_BITS(REFL_FRAC_BITS)) u_refl_blue (
      .clock(clock), .rad(req_data.blue_radiance), .gain(gain_blue_ff), .refl(rb));
   pqm_refl #(.REFL_FRAC_BITS(REFL_FRAC_BITS)) u_refl_red (
      .clock(clock), .rad(req_data.red_radiance), .gain(gain_red_ff), .refl(rr));
   pqm_refl #(.REFL_FRAC_BITS(REFL_FRAC_BITS)) u_refl_nir (
      .clock(clock), .rad(req_data.nir_radiance), .gain(gain_nir_ff), .refl(rn));
   pqm_refl #(.REFL_FRAC_BITS(REFL_FRAC_BITS)) u_refl_swir (
      .clock(clock), .rad(req_data.swir_radiance), .gain(gain_swir_ff), .refl(rs));

   // Pixel validity and snow enable are settled as the item enters.
   assign ctrl1_in.pix_ok  = (req_data.blue_radiance != '0) && (req_data.red_radiance != '0)
                             && (req_data.nir_radiance != '0);
   assign ctrl1_in.snow_on = swir_enable_ff && (req_data.swir_radiance != '0);
   assign ctrl1_in.last    = req_data.last_pixel;

   // Scaled reflectances for the cross-multiplied ratio tests.
   assign rn_x2 = {2'b00, rn, 1'b0};
   assign rr_x3 = {2'b00, rr, 1'b0} + {3'b000, rr};
   assign rb_x3 = {2'b00, rb, 1'b0} + {3'b000, rb};
   assign rs_x7 = {rs, 3'b000} - {3'b000, rs};

   // Third stage: threshold and ratio compares.
   always_comb begin
      flags3_in.rb_gt25   = rb > T25;
      flags3_in.rn_gt60   = rn > T60;
      flags3_in.ndvi_lt02 = ((rn == '0) && (rr == '0)) || (rn_x2 < rr_x3);
      flags3_in.ndvi_lt0  = rn < rr;
      flags3_in.rb_lt4    = rb < T4;
      flags3_in.rr_lt4    = rr < T4;
      flags3_in.rn_lt4    = rn < T4;
      flags3_in.rn_lt5    = rn < T5;
      flags3_in.rn_gt10   = rn > T10;
      flags3_in.ndsi_gt04 = rb_x3 > rs_x7;
   end

   // Fourth stage: assemble the mask into the output register.
   always_comb begin
      rsp_in.quality_bits = '0;
      rsp_in.scene_end    = ctrl3_ff.last;
      if (ctrl3_ff.pix_ok) begin
         rsp_in.quality_bits[Q_CLOUD_BIT]  = (flags3_ff.rb_gt25 && flags3_ff.ndvi_lt02)
                                             || flags3_ff.rn_gt60;
         rsp_in.quality_bits[Q_SHADOW_BIT] = flags3_ff.rb_lt4 && flags3_ff.rr_lt4
                                             && flags3_ff.rn_lt4;
         rsp_in.quality_bits[Q_WATER_BIT]  = flags3_ff.rn_lt5 && flags3_ff.ndvi_lt0;
         rsp_in.quality_bits[Q_SNOW_BIT]   = ctrl3_ff.snow_on && flags3_ff.ndsi_gt04
                                             && flags3_ff.rn_gt10;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         valid3_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid1_ff    <= accept;
         valid2_ff    <= valid1_ff;
         valid3_ff    <= valid2_ff;
         rsp_valid_ff <= valid3_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ctrl1_ff  <= ctrl1_in;
      ctrl2_ff  <= ctrl1_ff;
      ctrl3_ff  <= ctrl2_ff;
      flags3_ff <= flags3_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/pqm_checker.sv
// Port-level checks for the pixel quality mask, bound onto the top level.
// Depends on pqm_pkg and on the port list of pixel_quality_mask_top.
module pqm_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input pqm_pkg::req_type req_data,
   input logic             rsp_valid,
   input pqm_pkg::rsp_type rsp_data
);
   import pqm_pkg::*;

   // An item that sees no reset on its way through.
   sequence clean_item;
      (start && !busy && !reset) ##1 !reset ##1 !reset ##1 !reset;
   endsequence

   // Every accepted item that sees no reset on its way through yields a result.
   a_result_follows: assert property (@(posedge clock)
      clean_item |-> ##1 rsp_valid)
      else $error("accepted item produced no result");

   // No result appears without an accepted item ahead of it in the pipeline.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result without a matching item");

   // The scene end flag belongs to the same item.
   a_scene_end: assert property (@(posedge clock)
      clean_item |-> ##1 (rsp_data.scene_end == $past(req_data.last_pixel, 4)))
      else $error("scene end does not match its item");

   // A pixel with a zero visible or near infrared sample gets an empty mask.
   a_invalid_zero: assert property (@(posedge clock)
      clean_item |-> ##1 (!($past(req_data.blue_radiance == '0
                                  || req_data.red_radiance == '0
                                  || req_data.nir_radiance == '0, 4))
                          || rsp_data.quality_bits == '0))
      else $error("invalid pixel with a non-empty mask");

   // Cloud needs a bright band and shadow needs blue, red and near infrared all dark.
   a_cloud_shadow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.quality_bits[Q_CLOUD_BIT] && rsp_data.quality_bits[Q_SHADOW_BIT]))
      else $error("cloud and shadow set together");

endmodule

bind pixel_quality_mask_top pqm_checker u_pqm_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_data(rsp_data)
);
